// ----- design/hss_pkg.sv -----
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types and constants of the header signature sniffer: the signature
// table, printable byte bounds and the snapshot handed to the verdict stage.
// ----------------------------------------------------------------------------
package hss_pkg;

    localparam int SIG_COUNT = 12;
    localparam int SIG_BYTES = 8;

    // position saturates at all ones
    localparam logic [13:0] POS_MAX = 14'h3FFF;

    localparam logic [6:0] TEXT_PERCENT_RESET = 7'd85;

    // register indexes on the configuration port
    localparam logic REG_TEXT_PERCENT = 1'b0;

    // printable bytes, the accepted control characters and the nul byte
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // signature order: zip, tar, gzip, png, flac, id3, mpeg sync, jxl box,
    // jxl raw, jpeg soi, ape, wv
    localparam logic [13:0] SIG_OFFSET [SIG_COUNT] = '{
        14'd0, 14'd257, 14'd0, 14'd0, 14'd0, 14'd0,
        14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0
    };

    // first position past each signature
    localparam logic [13:0] SIG_END [SIG_COUNT] = '{
        14'd4, 14'd262, 14'd2, 14'd8, 14'd4, 14'd3,
        14'd2, 14'd8, 14'd2, 14'd3, 14'd4, 14'd4
    };

    localparam logic [7:0] SIG_EXPECT [SIG_COUNT][SIG_BYTES] = '{
        '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00},
        '{8'h1F, 8'h8B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'h66, 8'h4C, 8'h61, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h44, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0C, 8'h4A, 8'h58, 8'h4C, 8'h20},
        '{8'hFF, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h41, 8'h43, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h76, 8'h70, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] SIG_MASK [SIG_COUNT][SIG_BYTES] = '{
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
        '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // header totals at the end marker
    typedef struct packed {
        logic [SIG_COUNT-1:0] hits;
        logic [13:0]          position;
        logic [13:0]          printable;
        logic                 nul;
    } snap_t;

endpackage

// ----- design/hss_track.sv -----
// ----------------------------------------------------------------------------
// hss_track
// Per-header tracking: signature match bits, byte position, printable count
// and nul flag. Produces the header totals for the byte being stepped.
// ----------------------------------------------------------------------------
module hss_track #(
    parameter logic [13:0] SAMPLE_LIM = 14'd8192
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    byte_value,
    input  logic          byte_present,
    input  logic          last_byte,
    output hss_pkg::snap_t snap
);

    logic [13:0]                   pos_reg;
    logic [13:0]                   pos_next;
    logic [13:0]                   print_reg;
    logic [13:0]                   print_next;
    logic                          nul_reg;
    logic                          nul_next;
    logic [hss_pkg::SIG_COUNT-1:0] match_reg;
    logic [hss_pkg::SIG_COUNT-1:0] match_next;

    logic [13:0]                   pos_new;
    logic [13:0]                   print_new;
    logic                          nul_new;
    logic [hss_pkg::SIG_COUNT-1:0] match_new;
    logic                          take;
    logic                          sampled;
    logic                          printable;

    assign take      = byte_present && (pos_reg != hss_pkg::POS_MAX);
    assign sampled   = pos_reg < SAMPLE_LIM;
    assign printable = ((byte_value >= hss_pkg::PRINT_LO) && (byte_value <= hss_pkg::PRINT_HI))
                    || (byte_value == hss_pkg::CH_TAB) || (byte_value == hss_pkg::CH_LF)
                    || (byte_value == hss_pkg::CH_CR);

    always_comb
    begin
        logic [13:0] rel;
        logic [2:0]  idx;
        match_new = match_reg;
        for (int k = 0; k < hss_pkg::SIG_COUNT; k++)
        begin
            rel = pos_reg - hss_pkg::SIG_OFFSET[k];
            idx = rel[2:0];
            if (take && (pos_reg >= hss_pkg::SIG_OFFSET[k]) && (pos_reg < hss_pkg::SIG_END[k]))
            begin
                if ((byte_value & hss_pkg::SIG_MASK[k][idx]) != hss_pkg::SIG_EXPECT[k][idx])
                begin
                    match_new[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        pos_new   = pos_reg;
        print_new = print_reg;
        nul_new   = nul_reg;
        if (take)
        begin
            pos_new = pos_reg + 14'd1;
            if (sampled)
            begin
                if (byte_value == hss_pkg::CH_NUL)
                begin
                    nul_new = 1'b1;
                end
                if (printable && (print_reg != hss_pkg::POS_MAX))
                begin
                    print_new = print_reg + 14'd1;
                end
            end
        end
    end

    // a signature hits only once the header covers all of it
    always_comb
    begin
        for (int k = 0; k < hss_pkg::SIG_COUNT; k++)
        begin
            snap.hits[k] = match_new[k] && (pos_new >= hss_pkg::SIG_END[k]);
        end
        snap.position  = pos_new;
        snap.printable = print_new;
        snap.nul       = nul_new;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        print_next = print_reg;
        nul_next   = nul_reg;
        match_next = match_reg;
        if (step)
        begin
            if (last_byte)
            begin
                pos_next   = '0;
                print_next = '0;
                nul_next   = 1'b0;
                match_next = '1;
            end
            else
            begin
                pos_next   = pos_new;
                print_next = print_new;
                nul_next   = nul_new;
                match_next = match_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            print_reg <= '0;
            nul_reg   <= 1'b0;
            match_reg <= '1;
        end
        else
        begin
            pos_reg   <= pos_next;
            print_reg <= print_next;
            nul_reg   <= nul_next;
            match_reg <= match_next;
        end
    end

endmodule

// ----- design/hss_verdict.sv -----
// ----------------------------------------------------------------------------
// hss_verdict
// Text verdict: sample nonempty, nul free and printable share at or above
// the configured percent.
// ----------------------------------------------------------------------------
module hss_verdict #(
    parameter logic [13:0] SAMPLE_LIM = 14'd8192
) (
    input  hss_pkg::snap_t snap,
    input  logic [6:0]     text_percent,
    output logic           text_like
);

    logic [13:0] sample_len;
    logic [20:0] print_scaled;
    logic [20:0] need_scaled;

    assign sample_len   = (snap.position < SAMPLE_LIM) ? snap.position : SAMPLE_LIM;
    assign print_scaled = 21'(snap.printable) * 21'd100;
    assign need_scaled  = 21'(text_percent) * 21'(sample_len);

    assign text_like = (sample_len != 14'd0) && !snap.nul && (print_scaled >= need_scaled);

endmodule

// ----- design/header_signature_sniffer_unit.sv -----
// ----------------------------------------------------------------------------
// header_signature_sniffer_unit
// File magic detection over a streamed header, with a text/binary verdict
// on the first SAMPLE_BYTES bytes, capped at 16383.
// ----------------------------------------------------------------------------
//  channel   signals                                      word
//  byte      byte_valid/byte_ready                        byte_value, byte_present,
//                                                         last_byte
//  result    result_valid/result_ready                    signature_hits, text_like
//  config    psel/penable/pwrite/paddr/pwdata/prdata      text_percent at 0x0
//
//  one byte word per cycle while byte_ready is high; after its end marker is
//  taken, a result moves through input register, header totals register, result register
//  present bytes without an end marker update the tracking state and produce nothing
//  reset clears the tracking state and sets text_percent to 85
//  a stalled result holds its register; byte_ready drops only once the totals
//  register and the result register are both full
// ----------------------------------------------------------------------------
module header_signature_sniffer_unit #(
    parameter int SAMPLE_BYTES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  byte_value,
    input  logic        byte_present,
    input  logic        last_byte,

    output logic        result_valid,
    input  logic        result_ready,
    output logic [11:0] signature_hits,
    output logic        text_like,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          SAMPLE_CAP = (SAMPLE_BYTES < 16383) ? SAMPLE_BYTES : 16383;
    localparam logic [13:0] SAMPLE_LIM = 14'(SAMPLE_CAP);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_last_reg;

    // header totals register
    logic           snap_valid_reg;
    logic           snap_valid_next;
    hss_pkg::snap_t snap_reg;
    hss_pkg::snap_t snap_new;

    // result register
    logic        res_valid_reg;
    logic        res_valid_next;
    logic [11:0] hits_reg;
    logic        text_reg;
    logic        text_new;

    logic [6:0] text_percent_reg;

    logic res_free;
    logic snap_move;
    logic snap_free;
    logic in_move;
    logic in_take;
    logic cfg_write;

    assign res_free  = !res_valid_reg || result_ready;
    assign snap_move = snap_valid_reg && res_free;
    assign snap_free = !snap_valid_reg || res_free;
    // only end markers need a slot downstream
    assign in_move   = in_valid_reg && (!in_last_reg || snap_free);
    assign byte_ready = !in_valid_reg || in_move;
    assign in_take   = byte_valid && byte_ready;

    assign in_valid_next   = in_take || (in_valid_reg && !in_move);
    assign snap_valid_next = (in_move && in_last_reg) || (snap_valid_reg && !snap_move);
    assign res_valid_next  = snap_move || (res_valid_reg && !result_ready);

    hss_track #(
        .SAMPLE_LIM(SAMPLE_LIM)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_move),
        .byte_value  (in_byte_reg),
        .byte_present(in_present_reg),
        .last_byte   (in_last_reg),
        .snap        (snap_new)
    );

    hss_verdict #(
        .SAMPLE_LIM(SAMPLE_LIM)
    ) u_verdict (
        .snap        (snap_reg),
        .text_percent(text_percent_reg),
        .text_like   (text_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            snap_valid_reg <= snap_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg    <= byte_value;
            in_present_reg <= byte_present;
            in_last_reg    <= last_byte;
        end
        if (in_move && in_last_reg)
        begin
            snap_reg <= snap_new;
        end
        if (snap_move)
        begin
            hits_reg <= snap_reg.hits;
            text_reg <= text_new;
        end
    end

    assign result_valid   = res_valid_reg;
    assign signature_hits = hits_reg;
    assign text_like      = text_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == hss_pkg::REG_TEXT_PERCENT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_percent_reg <= hss_pkg::TEXT_PERCENT_RESET;
        end
        else if (cfg_write)
        begin
            text_percent_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == hss_pkg::REG_TEXT_PERCENT) ? {25'd0, text_percent_reg} : 32'd0;

    // a waiting header total is never dropped
    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !res_free |=> snap_valid_reg)
        else $error("header totals lost while result stalled");

    // totals that move always produce a result
    a_snap_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        snap_move |=> res_valid_reg)
        else $error("totals moved without a result");

    // a nul in the sample can never give a text verdict
    a_nul_not_text: assert property (@(posedge clk) disable iff (!rst_n)
        snap_move && snap_reg.nul |=> !text_reg)
        else $error("text verdict with nul in sample");

    // an empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> byte_ready)
        else $error("byte_ready low with empty input register");

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// header signature sniffer testbench
// Streams file headers into the byte channel and checks the signature hit mask
// and text verdict of each header against an in-bench predictor. Covers the
// text_percent register, absent and empty words, truncated and corrupted
// signatures and the ustar signature at its offset. The sender and receiver
// idle at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE       = 8192;
    localparam int POS_CAP      = 16383;
    localparam int N_MAGIC      = 12;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [6:0] PCT_AT_RESET = 7'd85;
    localparam logic [2:0] PCT_ADDR     = {hss_pkg::REG_TEXT_PERCENT, 2'b00};

    typedef enum int {
        M_ZIP, M_TAR, M_GZIP, M_PNG, M_FLAC, M_ID3, M_MPEG, M_JXLBOX,
        M_JXLRAW, M_JPEG, M_APE, M_WV, M_NONE
    } magic_e;

    typedef enum int {FILL_TEXT, FILL_BINARY, FILL_MIXED} fill_e;

    // magic bytes packed with byte 0 in the low bits
    localparam int SIG_START [N_MAGIC] = '{0, 257, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam int SIG_SPAN  [N_MAGIC] = '{4, 5, 2, 8, 4, 3, 2, 8, 2, 3, 4, 4};
    localparam logic [63:0] MAGIC_BYTES [N_MAGIC] = '{
        64'h04034B50, 64'h7261747375, 64'h8B1F, 64'h0A1A0A0D474E5089,
        64'h43614C66, 64'h334449, 64'hE0FF, 64'h204C584A0C000000,
        64'h0AFF, 64'hFFD8FF, 64'h2043414D, 64'h6B707677
    };
    localparam logic [63:0] MAGIC_MASK [N_MAGIC] = '{
        64'hFFFFFFFF, 64'hFFFFFFFFFF, 64'hFFFF, 64'hFFFFFFFFFFFFFFFF,
        64'hFFFFFFFF, 64'hFFFFFF, 64'hE0FF, 64'hFFFFFFFFFFFFFFFF,
        64'hFFFF, 64'hFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFF
    };

    typedef struct packed {
        logic [11:0] hits;
        logic        text;
    } verdict_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    logic [7:0]  byte_value   = 8'h00;
    logic        byte_present = 1'b0;
    logic        last_byte    = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [11:0] signature_hits;
    logic        text_like;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    int          hdr_pos       = 0;
    int          hdr_printable = 0;
    logic        hdr_nul       = 1'b0;
    logic [11:0] hdr_live      = 12'hFFF;
    logic [6:0]  pct_now       = PCT_AT_RESET;

    verdict_t    pending_verdicts [$];
    logic [7:0]  header_buf [$];

    int send_idle     = 0;
    int recv_idle     = 0;
    int words_sent    = 0;
    int verdicts_seen = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;

    header_signature_sniffer_unit #(.SAMPLE_BYTES(SAMPLE)) DUT (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
        result_ready <= ($urandom_range(0, 99) >= recv_idle);

    function automatic void absorb_byte(input logic [7:0] b);
        int k;
        int rel;
        if (hdr_pos >= POS_CAP)
            return;
        for (k = 0; k < N_MAGIC; k++)
        begin
            rel = hdr_pos - SIG_START[k];
            if (rel >= 0 && rel < SIG_SPAN[k])
                if ((b & MAGIC_MASK[k][8*rel +: 8]) != MAGIC_BYTES[k][8*rel +: 8])
                    hdr_live[k] = 1'b0;
        end
        if (hdr_pos < SAMPLE)
        begin
            if (b == 8'h00)
                hdr_nul = 1'b1;
            if ((b >= 8'd32 && b <= 8'd126) || b == 8'h09 || b == 8'h0A || b == 8'h0D)
                hdr_printable++;
        end
        hdr_pos++;
    endfunction

    // verdict at the end marker, then back to a fresh header
    function automatic verdict_t close_header();
        verdict_t v;
        int k;
        int n;
        v.hits = 12'h000;
        for (k = 0; k < N_MAGIC; k++)
            if (hdr_live[k] && hdr_pos >= SIG_START[k] + SIG_SPAN[k])
                v.hits[k] = 1'b1;
        n = (hdr_pos < SAMPLE) ? hdr_pos : SAMPLE;
        v.text = (n > 0) && !hdr_nul && (hdr_printable * 100 >= int'(pct_now) * n);
        hdr_pos       = 0;
        hdr_printable = 0;
        hdr_nul       = 1'b0;
        hdr_live      = 12'hFFF;
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result, hits %03h text %0b",
                             $time, signature_hits, text_like);
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    verdicts_seen++;
                    if (signature_hits !== want.hits)
                    begin
                        $display("%0t: signature_hits expected %03h actual %03h",
                                 $time, want.hits, signature_hits);
                        fail_count++;
                    end
                    if (text_like !== want.text)
                    begin
                        $display("%0t: text_like expected %0b actual %0b",
                                 $time, want.text, text_like);
                        fail_count++;
                    end
                end
            end
            if (byte_valid && byte_ready)
            begin
                if (byte_present)
                    absorb_byte(byte_value);
                if (last_byte)
                    pending_verdicts.push_back(close_header());
            end
            if (psel && penable && pwrite && pready && paddr == PCT_ADDR)
                pct_now = pwdata[6:0];
            if ((byte_valid && byte_ready) || (result_valid && result_ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("header_signature_sniffer_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_percent_reg(input logic [6:0] want);
        logic [31:0] got;
        apb_read(PCT_ADDR, got);
        if (got !== {25'd0, want})
        begin
            $display("%0t: text_percent read expected %08h actual %08h",
                     $time, {25'd0, want}, got);
            fail_count++;
        end
    endtask

    // let every pending verdict come out, then let the unit drain
    task automatic settle();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_text_percent(input logic [6:0] pct);
        settle();
        apb_write(PCT_ADDR, {25'd0, pct});
        check_percent_reg(pct);
    endtask

    task automatic send_word(input logic [7:0] v, input logic here, input logic eoh);
        while ($urandom_range(0, 99) < send_idle)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid   <= 1'b1;
        byte_value   <= v;
        byte_present <= here;
        last_byte    <= eoh;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        if (here || eoh)
            words_sent++;
    endtask

    // sends header_buf; the end marker rides on the last byte or on an empty word
    task automatic ship_header(input int absent_pct, input logic marker_alone);
        int i;
        int last_idx;
        last_idx = header_buf.size() - 1;
        for (i = 0; i <= last_idx; i++)
        begin
            if ($urandom_range(0, 99) < absent_pct)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(header_buf[i], 1'b1, (i == last_idx) && !marker_alone);
        end
        if (marker_alone || last_idx < 0)
            send_word(8'($urandom), 1'b0, 1'b1);
        header_buf.delete();
    endtask

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 8'h09;
        if (r < 4)
            return 8'h0A;
        if (r < 5)
            return 8'h0D;
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] filler(input fill_e style);
        int r;
        r = $urandom_range(0, 99);
        if (style == FILL_TEXT || (style == FILL_MIXED && r < 50))
            return (r % 32 == 7) ? 8'($urandom_range(0, 255)) : text_char();
        if (r % 20 == 3)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic build_random_header();
        int    kind;
        int    i;
        int    idx;
        int    cut;
        int    tail;
        fill_e style;
        logic [7:0] b;
        kind  = $urandom_range(0, M_NONE);
        style = fill_e'($urandom_range(0, 2));
        // tar headers are long, keep them rarer
        if (kind == M_TAR && $urandom_range(0, 1) == 1)
            kind = M_NONE;
        if (kind != M_NONE)
        begin
            repeat (SIG_START[kind])
                header_buf.push_back(filler(style));
            for (i = 0; i < SIG_SPAN[kind]; i++)
            begin
                b = MAGIC_BYTES[kind][8*i +: 8];
                b = b | (8'($urandom) & ~MAGIC_MASK[kind][8*i +: 8]);
                header_buf.push_back(b);
            end
            case ($urandom_range(0, 9))
                0:
                begin
                    cut = $urandom_range(SIG_START[kind], header_buf.size() - 1);
                    while (header_buf.size() > cut)
                        void'(header_buf.pop_back());
                end
                1:
                begin
                    idx = $urandom_range(SIG_START[kind], header_buf.size() - 1);
                    header_buf[idx] = header_buf[idx] ^ 8'($urandom_range(1, 255));
                end
                default: ;
            endcase
        end
        case ($urandom_range(0, 19)) inside
            [0:13]:  tail = $urandom_range(0, 6);
            [14:18]: tail = $urandom_range(7, 40);
            default: tail = $urandom_range(41, 300);
        endcase
        repeat (tail)
            header_buf.push_back(filler(style));
    endtask

    task automatic test_register_reset_value();
        check_percent_reg(PCT_AT_RESET);
    endtask

    task automatic test_signature_basics();
        send_idle = 0;
        recv_idle = 0;
        // empty header: end marker with no byte
        ship_header(0, 1'b1);
        header_buf = '{8'h49, 8'h44, 8'h33};
        ship_header(0, 1'b1);
        // id3 cut short
        header_buf = '{8'h49, 8'h44};
        ship_header(0, 1'b0);
        header_buf = '{8'hFF, 8'hFF};
        ship_header(0, 1'b0);
        header_buf = '{8'h00};
        ship_header(0, 1'b0);
        header_buf = '{8'h09, 8'h0A, 8'h0D, 8'h7E, 8'h20, 8'h7F};
        ship_header(0, 1'b0);
        header_buf = '{8'hFF, 8'hD8, 8'hFF, 8'h1F};
        ship_header(0, 1'b0);
    endtask

    task automatic test_text_threshold();
        set_text_percent(7'd50);
        header_buf = '{8'h41, 8'h80};
        ship_header(0, 1'b0);
        set_text_percent(7'd51);
        header_buf = '{8'h41, 8'h80};
        ship_header(0, 1'b0);
        set_text_percent(7'd0);
        header_buf = '{8'h80};
        ship_header(0, 1'b0);
        header_buf = '{8'h00};
        ship_header(0, 1'b0);
        set_text_percent(7'd100);
        header_buf = '{8'h6F, 8'h6B};
        ship_header(0, 1'b0);
        // no sample can reach a share above 100
        set_text_percent(7'd127);
        header_buf = '{8'h6F, 8'h6B};
        ship_header(0, 1'b0);
    endtask

    task automatic test_random_headers(input int tx_idle, input int rx_idle,
                                       input logic [6:0] pct, input int quota);
        int stop_at;
        send_idle = tx_idle;
        recv_idle = rx_idle;
        set_text_percent(pct);
        stop_at = words_sent + quota;
        while (words_sent < stop_at)
        begin
            build_random_header();
            ship_header(($urandom_range(0, 4) == 0) ? 15 : 0, $urandom_range(0, 4) == 0);
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset_value();
        test_signature_basics();
        test_text_threshold();
        test_random_headers(13, 80, 7'($urandom_range(60, 95)), 650);
        test_random_headers(80, 13, 7'($urandom_range(0, 100)), 650);
        test_random_headers(0, 0, 7'($urandom_range(0, 127)), 650);
        settle();
        $display("checked %0d header verdicts over %0d byte words", verdicts_seen, words_sent);
        $display("text_percent swept 0 to 127, all twelve signatures whole, cut and corrupted");
        if (fail_count == 0)
            $display("header_signature_sniffer_unit: match");
        else
            $display("header_signature_sniffer_unit: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/hss_pkg.sv
design/hss_track.sv
design/hss_verdict.sv
design/header_signature_sniffer_unit.sv
tb/sv/tb.sv
